/* hdl/mlss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared types and constants for the longest subarray with a target sum.
// ----------------------------------------------------------------------------
package mlss_pkg;

   localparam int VALUE_BITS    = 16;
   localparam int TARGET_BITS   = 26;
   localparam int LEN_BITS      = 11;
   localparam int MAX_ITEMS_DEF = 1024;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] element_value;
      logic                         is_last;
   } req_word_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] longest_length;
      logic                too_long;
   } rsp_word_type;

endpackage
`default_nettype wire

/* hdl/mlss_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hdl/max_len_subarray_sum_target_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_len_subarray_sum_target_core
// Finds the longest contiguous run of array elements summing to a target.
// ----------------------------------------------------------------------------
// Elements arrive one word at a time on the req_ channel (valid/stall). The
// target is written through csr_wr_en / csr_wr_data; the user must write it
// only while the block is idle, since the block itself leaves this unchecked.
// For every element the block keeps a prefix sum and a table of the first
// position at which each distinct prefix sum was seen. The table sits in one
// RAM with a single read port, and each element scans all valid entries once;
// req_stall holds the next element until that scan and the table write are
// done. Elements beyond MAX_ITEMS only raise the overflow flag.
// On the element marked last, one word with the best length and the overflow
// flag is loaded into the rsp_ output register and the array state clears.
// The block keeps accepting elements while that word waits; if another result
// is ready before the receiver takes the first, it holds until rsp_stall drops.
// Synchronous reset clears the array state, the target and the output valid;
// the table contents need no clearing since only filled entries are read.
// ----------------------------------------------------------------------------
module max_len_subarray_sum_target_core #(
   parameter int MAX_ITEMS = mlss_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire mlss_pkg::req_word_type                  req_word,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output mlss_pkg::rsp_word_type                       rsp_word,
   input  wire logic                                    csr_wr_en,
   input  wire logic signed [mlss_pkg::TARGET_BITS-1:0] csr_wr_data
);

   import mlss_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = VALUE_BITS + IDX_W;
   localparam int CMP_W = ((SUM_W > TARGET_BITS) ? SUM_W : TARGET_BITS) + 1;
   localparam int ENT_W = SUM_W + IDX_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic [CNT_W-1:0]              best_ff, best_in;
   logic [CNT_W-1:0]              used_ff, used_in;
   logic [CNT_W-1:0]              scan_ff, scan_in;
   logic                          over_ff, over_in;
   logic                          last_ff, last_in;
   logic                          found_ff, found_in;
   logic                          rvalid_ff, rvalid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [TARGET_BITS-1:0] target_ff, target_in;
   logic signed [CMP_W-1:0]       wanted_ff, wanted_in;
   rsp_word_type                  rsp_word_ff, rsp_word_in;

   logic                          rd_en;
   logic [ENT_W-1:0]              rd_data;
   logic                          wr_en;
   logic signed [SUM_W-1:0]       ent_sum;
   logic [IDX_W-1:0]              ent_pos;
   logic [IDX_W-1:0]              run_len;

   assign ent_sum   = rd_data[ENT_W-1:IDX_W];
   assign ent_pos   = rd_data[IDX_W-1:0];
   assign run_len   = pos_ff[IDX_W-1:0] - ent_pos;
   assign rd_en     = (state_ff == S_SCAN) && (scan_ff != used_ff);
   assign wr_en     = (state_ff == S_WRITE) && !found_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   mlss_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ITEMS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (used_ff[IDX_W-1:0]),
      .wr_data ({sum_ff, pos_ff[IDX_W-1:0]}),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      over_in      = over_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      rvalid_in    = rd_en;
      target_in    = target_ff;
      wanted_in    = wanted_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         target_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_word.is_last;
               if (pos_ff == CNT_W'(MAX_ITEMS)) begin
                  over_in = 1'b1;
                  if (req_word.is_last) begin
                     state_in = S_DONE;
                  end
               end else begin
                  sum_in   = sum_ff + SUM_W'($signed(req_word.element_value));
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            // A prefix that itself hits the target is always the longest so far.
            if (CMP_W'(sum_ff) == CMP_W'(target_ff)) begin
               best_in = pos_ff + CNT_W'(1);
            end
            wanted_in = CMP_W'(sum_ff) - CMP_W'(target_ff);
            found_in  = 1'b0;
            scan_in   = '0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (rd_en) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            // Stored sums are distinct, so each compare matches at most one entry.
            if (rvalid_ff) begin
               if (CMP_W'(ent_sum) == wanted_ff && CNT_W'(run_len) > best_ff) begin
                  best_in = CNT_W'(run_len);
               end
               if (ent_sum == sum_ff) begin
                  found_in = 1'b1;
               end
            end
            if (!rd_en && !rvalid_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (!found_ff) begin
               used_in = used_ff + CNT_W'(1);
            end
            pos_in   = pos_ff + CNT_W'(1);
            state_in = last_ff ? S_DONE : S_IDLE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.longest_length = LEN_BITS'(best_ff);
               rsp_word_in.too_long       = over_ff;
               rsp_valid_in               = 1'b1;
               sum_in                     = '0;
               pos_in                     = '0;
               best_in                    = '0;
               used_in                    = '0;
               over_in                    = 1'b0;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         used_ff      <= '0;
         scan_ff      <= '0;
         over_ff      <= 1'b0;
         last_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         used_ff      <= used_in;
         scan_ff      <= scan_in;
         over_ff      <= over_in;
         last_ff      <= last_in;
         found_ff     <= found_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      wanted_ff   <= wanted_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
`default_nettype wire

/* sim/tb_max_len_subarray_sum_target_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_len_subarray_sum_target_core
// Self-checking bench for the longest subarray with a target sum.
// ----------------------------------------------------------------------------
// Arrays are sent one element word at a time. A scoreboard keeps its own
// prefix sums and first-seen positions, predicts the length word for every
// element marked last and compares each result word against the oldest
// prediction. A few directed arrays hit the value and target extremes and a
// target change in the middle of an array; random arrays follow, including
// one that runs past the table size. Both channels stall at random until
// the last part of the run.
// ----------------------------------------------------------------------------
module tb_max_len_subarray_sum_target_core;
   import mlss_pkg::*;

   localparam logic signed [TARGET_BITS-1:0] TARGET_LOW  = {1'b1, {(TARGET_BITS-1){1'b0}}};
   localparam logic signed [TARGET_BITS-1:0] TARGET_HIGH = {1'b0, {(TARGET_BITS-1){1'b1}}};
   localparam int RANDOM_ITEMS = 580;
   localparam int QUIET_AFTER  = 480;

   class run_length_scoreboard;
      longint       target;
      longint       running_total;
      int           element_count;
      int           best_run;
      bit           truncated;
      longint       seen_sums[$];
      int           seen_firsts[$];
      rsp_word_type expected_words[$];
      int           mismatches;

      function new();
         target     = 0;
         mismatches = 0;
         clear_array();
      endfunction

      function void clear_array();
         running_total = 0;
         element_count = 0;
         best_run      = 0;
         truncated     = 1'b0;
         seen_sums.delete();
         seen_firsts.delete();
      endfunction

      function void set_target(logic signed [TARGET_BITS-1:0] value);
         target = value;
      endfunction

      function void note_element(req_word_type w);
         longint       wanted;
         int           pos;
         bit           known;
         rsp_word_type want;
         if (element_count >= MAX_ITEMS_DEF) begin
            truncated = 1'b1;
         end else begin
            pos = element_count;
            running_total += longint'($signed(w.element_value));
            if (running_total == target) begin
               best_run = pos + 1;
            end
            wanted = running_total - target;
            foreach (seen_sums[k]) begin
               if (seen_sums[k] == wanted) begin
                  if (pos - seen_firsts[k] > best_run) begin
                     best_run = pos - seen_firsts[k];
                  end
                  break;
               end
            end
            known = 1'b0;
            foreach (seen_sums[k]) begin
               if (seen_sums[k] == running_total) begin
                  known = 1'b1;
               end
            end
            if (!known) begin
               seen_sums.push_back(running_total);
               seen_firsts.push_back(pos);
            end
            element_count = pos + 1;
         end
         if (w.is_last) begin
            want.longest_length = best_run[LEN_BITS-1:0];
            want.too_long       = truncated;
            expected_words.push_back(want);
            clear_array();
         end
      endfunction

      function void check_length(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: longest_length %0d, too_long %0b",
                   got.longest_length, got.too_long);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got.longest_length !== want.longest_length) begin
            $error("longest_length: expected %0d, actual %0d",
                   want.longest_length, got.longest_length);
            mismatches++;
         end
         if (got.too_long !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, got.too_long);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   req_word_type                  req_word    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   rsp_word_type                  rsp_word;
   logic                          csr_wr_en   = 1'b0;
   logic signed [TARGET_BITS-1:0] csr_wr_data = '0;

   run_length_scoreboard sb;
   bit quiet        = 1'b0;
   bit counting     = 1'b0;
   int random_items = 0;
   int stall_left   = 0;

   max_len_subarray_sum_target_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check accepted words, then pick the stall for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_length(rsp_word);
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clock);
   endtask

   task automatic send_element(input int value, input bit last);
      req_word_type w;
      w.element_value = value[VALUE_BITS-1:0];
      w.is_last       = last;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         pause_sender();
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_element(w);
      if (counting) begin
         random_items++;
      end
   endtask

   // Waits for every predicted word, then for the longest table scan, so the
   // block is idle even in the middle of an array.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (sb.seen_sums.size() + 8) @(posedge clock);
   endtask

   task automatic write_target(input logic signed [TARGET_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_target(value);
   endtask

   function automatic logic signed [TARGET_BITS-1:0] pick_target();
      case ($urandom_range(0, 5))
         0: return TARGET_LOW;
         1: return TARGET_HIGH;
         2, 3: return TARGET_BITS'(int'($urandom_range(0, 48)) - 24);
         4: return TARGET_BITS'($urandom);
         default: return '0;
      endcase
   endfunction

   function automatic int pick_value(input int kind);
      case (kind)
         0: return int'($urandom_range(0, 12)) - 6;
         1: return $urandom_range(0, 65535);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32767;
               1: return -32768;
               2: return -1;
               3: return 1;
               default: return 0;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_array();
      int len;
      int kind;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      kind = $urandom_range(0, 2);
      for (int idx = 0; idx < len; idx++) begin
         if (idx > 0 && !quiet && $urandom_range(0, 19) == 0) begin
            drain_results();
            write_target(pick_target());
         end
         send_element(pick_value(kind), idx == len - 1);
      end
   endtask

   // Runs past the table size. Prefix sums stay in a narrow band so the scan
   // stays short, and the full table sums to the target so the best run is
   // the whole table.
   task automatic send_long_array();
      int sum;
      int step;
      int goal;
      sum  = 0;
      goal = int'($urandom_range(0, 12)) - 6;
      drain_results();
      write_target(TARGET_BITS'(goal));
      for (int idx = 0; idx < MAX_ITEMS_DEF - 1; idx++) begin
         step = int'($urandom_range(0, 4)) - 2;
         if (sum + step > 6 || sum + step < -6) begin
            step = -step;
         end
         sum += step;
         send_element(step, 1'b0);
      end
      send_element(goal - sum, 1'b0);
      for (int idx = 0; idx < 3; idx++) begin
         send_element(pick_value(1), idx == 2);
      end
   endtask

   initial begin
      bit long_done;
      long_done = 1'b0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Target at its reset value of zero.
      send_element(5, 1'b1);
      send_element(32767, 1'b0);
      send_element(-32768, 1'b0);
      send_element(1, 1'b1);
      send_element(-32768, 1'b1);
      send_element(0, 1'b1);

      drain_results();
      write_target(TARGET_LOW);
      send_element(-32768, 1'b0);
      send_element(-32768, 1'b1);

      drain_results();
      write_target(TARGET_HIGH);
      send_element(32767, 1'b1);

      drain_results();
      write_target(TARGET_BITS'(-3));
      send_element(-1, 1'b0);
      send_element(-2, 1'b0);
      send_element(4, 1'b0);
      send_element(-3, 1'b1);

      // The target changes between the second and third element.
      drain_results();
      write_target(TARGET_BITS'(5));
      send_element(1, 1'b0);
      send_element(4, 1'b0);
      drain_results();
      write_target(TARGET_BITS'(6));
      send_element(6, 1'b0);
      send_element(0, 1'b1);

      counting = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         if (!long_done && random_items >= 200) begin
            counting = 1'b0;
            send_long_array();
            counting  = 1'b1;
            long_done = 1'b1;
         end
         if (random_items >= QUIET_AFTER) begin
            quiet = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            write_target(pick_target());
         end
         send_random_array();
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
hdl/mlss_pkg.sv
hdl/mlss_ram.sv
hdl/max_len_subarray_sum_target_core.sv
sim/tb_max_len_subarray_sum_target_core.sv
